### hw/rtl/qpft_pkg.sv
// qpft_pkg: types, codes and constants shared by the quoted pair file tokenizer
// no dependencies; imported by qpft_step, quoted_pair_file_tokenizer_core and tb_top

package qpft_pkg;

	// width of the saturating line counter
	localparam int LINE_BITS = 16;
	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

	// byte constants
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// input operation
	typedef enum logic {
		FUNC_BYTE = 1'b0,
		FUNC_EOF  = 1'b1
	} func_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_NAME  = 3'd0,
		KIND_KEY   = 3'd1,
		KIND_VALUE = 3'd2,
		KIND_PAIR  = 3'd3,
		KIND_END   = 3'd4,
		KIND_ERR   = 3'd5
	} kind_t;

	// error codes
	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_OPEN_QUOTE  = 3'd1,
		ERR_EQUALS      = 3'd2,
		ERR_UNTERM      = 3'd3,
		ERR_COMMENT     = 3'd4
	} err_t;

	// parse position, one-hot
	typedef enum logic [6:0] {
		PH_WAIT_HDR = 7'b0000001,
		PH_IN_HDR   = 7'b0000010,
		PH_WAIT_KEY = 7'b0000100,
		PH_IN_KEY   = 7'b0001000,
		PH_WAIT_EQ  = 7'b0010000,
		PH_WAIT_VAL = 7'b0100000,
		PH_IN_VAL   = 7'b1000000
	} phase_t;

	// comment tracking, one-hot
	typedef enum logic [4:0] {
		CM_NONE       = 5'b00001,
		CM_SLASH      = 5'b00010,
		CM_LINE       = 5'b00100,
		CM_BLOCK      = 5'b01000,
		CM_BLOCK_STAR = 5'b10000
	} cmt_t;

	// input beat
	typedef struct packed {
		func_t      func;
		logic [7:0] byte_in;
	} item_t;

	// output beat
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  char_out;
		logic [15:0] line_number;
		err_t        error_code;
	} result_t;

	// tokenizer state
	typedef struct packed {
		phase_t                phase;
		cmt_t                  cmt;
		logic                  esc;
		logic [LINE_BITS-1:0]  line_count;
		logic                  halted;
		err_t                  stop_code;
	} tok_state_t;

endpackage

### hw/rtl/qpft_step.sv
// qpft_step: next-state and result decode for one tokenizer beat
// depends on qpft_pkg

module qpft_step import qpft_pkg::*; (
	input  tok_state_t cur,
	input  item_t      item,
	output tok_state_t nxt,
	output logic       has_result,
	output result_t    res
);

	logic [7:0]           c;
	logic                 is_space;
	logic                 in_string;
	logic [LINE_BITS-1:0] lc_next;
	kind_t                str_kind;
	logic                 do_stop;
	err_t                 stop_err;
	logic                 emit_str;
	logic                 emit_pair;

	assign c = item.byte_in;
	assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	assign in_string = (cur.phase == PH_IN_HDR) || (cur.phase == PH_IN_KEY)
		|| (cur.phase == PH_IN_VAL);

	// saturating line count, bumped before the result is formed
	assign lc_next = ((c == CH_LF) && (cur.line_count != LINE_MAX))
		? cur.line_count + LINE_ONE : cur.line_count;

	// tag of a string byte
	always_comb begin
		case (cur.phase)
			PH_IN_HDR: str_kind = KIND_NAME;
			PH_IN_KEY: str_kind = KIND_KEY;
			default:   str_kind = KIND_VALUE;
		endcase
	end

	// main decode
	always_comb begin
		nxt       = cur;
		do_stop   = 1'b0;
		stop_err  = ERR_NONE;
		emit_str  = 1'b0;
		emit_pair = 1'b0;
		if (cur.halted) begin
			// sticky: repeat halting result below
		end else if (item.func == FUNC_EOF) begin
			do_stop = 1'b1;
			if (in_string)
				stop_err = ERR_UNTERM;
			else if (cur.cmt == CM_SLASH)
				stop_err = ERR_COMMENT;
			else if (cur.phase == PH_WAIT_KEY)
				stop_err = ERR_NONE;
			else if (cur.phase == PH_WAIT_EQ)
				stop_err = ERR_EQUALS;
			else
				stop_err = ERR_OPEN_QUOTE;
		end else begin
			nxt.line_count = lc_next;
			if (in_string) begin
				if (cur.esc) begin
					nxt.esc  = 1'b0;
					emit_str = 1'b1;
				end else if (c == CH_BSLASH) begin
					nxt.esc = 1'b1;
				end else if (c == CH_QUOTE) begin
					case (cur.phase)
						PH_IN_HDR: nxt.phase = PH_WAIT_KEY;
						PH_IN_KEY: nxt.phase = PH_WAIT_EQ;
						default: begin
							nxt.phase = PH_WAIT_KEY;
							emit_pair = 1'b1;
						end
					endcase
				end else begin
					emit_str = 1'b1;
				end
			end else begin
				case (cur.cmt)
					CM_SLASH: begin
						if (c == CH_SLASH)
							nxt.cmt = CM_LINE;
						else if (c == CH_STAR)
							nxt.cmt = CM_BLOCK;
						else begin
							do_stop  = 1'b1;
							stop_err = ERR_COMMENT;
						end
					end
					CM_LINE: begin
						if (c == CH_LF)
							nxt.cmt = CM_NONE;
					end
					CM_BLOCK: begin
						if (c == CH_STAR)
							nxt.cmt = CM_BLOCK_STAR;
					end
					CM_BLOCK_STAR: begin
						if (c == CH_SLASH)
							nxt.cmt = CM_NONE;
						else if (c != CH_STAR)
							nxt.cmt = CM_BLOCK;
					end
					default: begin
						// between tokens
						if (is_space) begin
						end else if (c == CH_SLASH) begin
							nxt.cmt = CM_SLASH;
						end else if (cur.phase == PH_WAIT_EQ) begin
							if (c == CH_EQUALS)
								nxt.phase = PH_WAIT_VAL;
							else begin
								do_stop  = 1'b1;
								stop_err = ERR_EQUALS;
							end
						end else if (c == CH_QUOTE) begin
							case (cur.phase)
								PH_WAIT_HDR: nxt.phase = PH_IN_HDR;
								PH_WAIT_KEY: nxt.phase = PH_IN_KEY;
								default:     nxt.phase = PH_IN_VAL;
							endcase
							nxt.esc = 1'b0;
						end else begin
							do_stop  = 1'b1;
							stop_err = ERR_OPEN_QUOTE;
						end
					end
				endcase
			end
		end
		if (do_stop) begin
			nxt.halted    = 1'b1;
			nxt.stop_code = stop_err;
		end
	end

	// result beat
	always_comb begin
		res             = '0;
		res.line_number = 16'(nxt.line_count);
		has_result      = cur.halted || do_stop || emit_str || emit_pair;
		if (cur.halted || do_stop) begin
			res.kind       = (nxt.stop_code == ERR_NONE) ? KIND_END : KIND_ERR;
			res.error_code = nxt.stop_code;
		end else if (emit_pair) begin
			res.kind = KIND_PAIR;
		end else begin
			res.kind     = str_kind;
			res.char_out = c;
		end
	end

endmodule

### hw/rtl/quoted_pair_file_tokenizer_core.sv
// quoted_pair_file_tokenizer_core: top level, input register, state and result register
// depends on qpft_pkg and qpft_step
//
//   channel | valid        | stall        | payload
//   input   | item_valid   | item_stall   | item   (item_t: func, byte_in)
//   output  | result_valid | result_stall | result (result_t: kind, char_out,
//           |              |              |         line_number, error_code)
//
// one byte per cycle sustained while the output is not stalled
// the per-byte decode sits combinationally between the input register and the result register
// bytes that produce no result leave the output data untouched but clear result_valid
// reset clears the parse state, the line count to one and both valid flags
// a stalled output holds its beat; the input register keeps taking bytes while it is empty,
// or while the output register is empty or being drained

module quoted_pair_file_tokenizer_core import qpft_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic       valid_s1;
	item_t      item_s1;
	tok_state_t st_q;
	tok_state_t st_next;
	logic       out_valid_q;
	result_t    out_q;
	logic       step_res;
	result_t    step_out;
	logic       advance;

	// stage 1 moves on when the output register has room
	assign advance    = ~out_valid_q | ~result_stall;
	assign item_stall = valid_s1 & ~advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// per-byte decode
	qpft_step u_step (
		.cur        (st_q),
		.item       (item_s1),
		.nxt        (st_next),
		.has_result (step_res),
		.res        (step_out)
	);

	// tokenizer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase      <= PH_WAIT_HDR;
			st_q.cmt        <= CM_NONE;
			st_q.esc        <= 1'b0;
			st_q.line_count <= LINE_ONE;
			st_q.halted     <= 1'b0;
			st_q.stop_code  <= ERR_NONE;
		end else if (valid_s1 && advance) begin
			st_q <= st_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 & step_res;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && step_res) begin
			out_q <= step_out;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// once halted, the held beat is the end or error result
	a_halt_out: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.halted && out_valid_q |-> (out_q.kind == KIND_END || out_q.kind == KIND_ERR))
		else $error("non-terminal beat held after halt");

	// error kind and nonzero code go together
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.kind == KIND_ERR) == (out_q.error_code != ERR_NONE)))
		else $error("error kind and code disagree");

	// line count starts at one and never wraps to zero
	a_line_nz: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.line_count != '0)
		else $error("line count reached zero");

	// a byte held in stage 1 stays put while the output is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1) && $stable(st_q))
		else $error("stage 1 lost a byte under stall");

	// state only moves when a byte passes stage 1
	a_state_move: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> $stable(st_q))
		else $error("state changed with no byte");

endmodule

### bench/tb_top.sv
// tb_top: self-checking bench for quoted_pair_file_tokenizer_core
// needs qpft_pkg and the core rtl; a built-in token predictor checks every output beat

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import qpft_pkg::*;

	// whitespace bytes without a name in the package
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	localparam int unsigned CYCLE_LIMIT = 100000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned MAX_GAP = 60;

	// ways the file can end; halting is sticky, so a run ends only once
	typedef enum int {
		END_EMPTY_FILE,
		END_STRAY_BEFORE_HDR,
		END_EOF_IN_HDR,
		END_CLEAN,
		END_EOF_LINE_CMT,
		END_EOF_BLOCK_CMT,
		END_EOF_AFTER_SLASH,
		END_BAD_COMMENT_START,
		END_STRAY_AT_KEY,
		END_EOF_IN_KEY,
		END_EOF_ESC_VALUE,
		END_STRAY_AT_EQUALS,
		END_EOF_AT_EQUALS,
		END_EOF_AT_VALUE,
		END_STRAY_AT_VALUE
	} file_ending_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int unsigned hold_request = 0;
	int unsigned sink_hold_left = 0;
	int unsigned items_sent = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	result_t expected_tokens[$];

	// predictor state
	phase_t               tok_phase = PH_WAIT_HDR;
	cmt_t                 tok_cmt = CM_NONE;
	logic                 tok_esc = 1'b0;
	logic [LINE_BITS-1:0] tok_line = LINE_ONE;
	logic                 tok_halted = 1'b0;
	err_t                 tok_stop = ERR_NONE;

	quoted_pair_file_tokenizer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic result_t make_token(kind_t k, logic [7:0] ch, err_t code);
		result_t r;
		r.kind = k;
		r.char_out = ch;
		r.line_number = 16'(tok_line);
		r.error_code = code;
		return r;
	endfunction

	function automatic result_t halt_on(err_t code);
		tok_halted = 1'b1;
		tok_stop = code;
		return make_token((code == ERR_NONE) ? KIND_END : KIND_ERR, 8'h00, code);
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// advances the token state by one beat; returns 1 when a token comes out
	function automatic bit predict_token(input item_t it, output result_t res);
		logic [7:0] c;
		kind_t      sk;
		c = it.byte_in;
		res = '0;
		if (tok_halted) begin
			res = make_token((tok_stop == ERR_NONE) ? KIND_END : KIND_ERR, 8'h00, tok_stop);
			return 1'b1;
		end

		// end of file
		if (it.func == FUNC_EOF) begin
			if (tok_phase == PH_IN_HDR || tok_phase == PH_IN_KEY || tok_phase == PH_IN_VAL)
				res = halt_on(ERR_UNTERM);
			else if (tok_cmt == CM_SLASH)
				res = halt_on(ERR_COMMENT);
			else if (tok_phase == PH_WAIT_KEY)
				res = halt_on(ERR_NONE);
			else if (tok_phase == PH_WAIT_EQ)
				res = halt_on(ERR_EQUALS);
			else
				res = halt_on(ERR_OPEN_QUOTE);
			return 1'b1;
		end

		// every newline counts, saturating
		if (c == CH_LF && tok_line != LINE_MAX)
			tok_line = tok_line + LINE_ONE;

		// inside a string
		if (tok_phase == PH_IN_HDR || tok_phase == PH_IN_KEY || tok_phase == PH_IN_VAL) begin
			sk = (tok_phase == PH_IN_HDR) ? KIND_NAME :
				(tok_phase == PH_IN_KEY) ? KIND_KEY : KIND_VALUE;
			if (tok_esc) begin
				tok_esc = 1'b0;
				res = make_token(sk, c, ERR_NONE);
				return 1'b1;
			end
			if (c == CH_BSLASH) begin
				tok_esc = 1'b1;
				return 1'b0;
			end
			if (c == CH_QUOTE) begin
				case (tok_phase)
					PH_IN_HDR: tok_phase = PH_WAIT_KEY;
					PH_IN_KEY: tok_phase = PH_WAIT_EQ;
					default: begin
						tok_phase = PH_WAIT_KEY;
						res = make_token(KIND_PAIR, 8'h00, ERR_NONE);
						return 1'b1;
					end
				endcase
				return 1'b0;
			end
			res = make_token(sk, c, ERR_NONE);
			return 1'b1;
		end

		// comments between tokens
		case (tok_cmt)
			CM_SLASH: begin
				if (c == CH_SLASH) begin
					tok_cmt = CM_LINE;
					return 1'b0;
				end
				if (c == CH_STAR) begin
					tok_cmt = CM_BLOCK;
					return 1'b0;
				end
				res = halt_on(ERR_COMMENT);
				return 1'b1;
			end
			CM_LINE: begin
				if (c == CH_LF)
					tok_cmt = CM_NONE;
				return 1'b0;
			end
			CM_BLOCK: begin
				if (c == CH_STAR)
					tok_cmt = CM_BLOCK_STAR;
				return 1'b0;
			end
			CM_BLOCK_STAR: begin
				if (c == CH_SLASH)
					tok_cmt = CM_NONE;
				else if (c != CH_STAR)
					tok_cmt = CM_BLOCK;
				return 1'b0;
			end
			default: ;
		endcase

		// plain bytes between tokens
		if (is_blank(c))
			return 1'b0;
		if (c == CH_SLASH) begin
			tok_cmt = CM_SLASH;
			return 1'b0;
		end
		if (tok_phase == PH_WAIT_EQ) begin
			if (c == CH_EQUALS) begin
				tok_phase = PH_WAIT_VAL;
				return 1'b0;
			end
			res = halt_on(ERR_EQUALS);
			return 1'b1;
		end
		if (c == CH_QUOTE) begin
			tok_phase = (tok_phase == PH_WAIT_HDR) ? PH_IN_HDR :
				(tok_phase == PH_WAIT_KEY) ? PH_IN_KEY : PH_IN_VAL;
			tok_esc = 1'b0;
			return 1'b0;
		end
		res = halt_on(ERR_OPEN_QUOTE);
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_token(result_t got);
		result_t want;
		if (expected_tokens.size() == 0) begin
			report_mismatch("unexpected token kind", got.kind, 0);
			return;
		end
		want = expected_tokens.pop_front();
		if (got.kind !== want.kind)
			report_mismatch("kind", got.kind, want.kind);
		if (got.char_out !== want.char_out)
			report_mismatch("char_out", got.char_out, want.char_out);
		if (got.line_number !== want.line_number)
			report_mismatch("line_number", got.line_number, want.line_number);
		if (got.error_code !== want.error_code)
			report_mismatch("error_code", got.error_code, want.error_code);
	endtask

	// output side: random stall or a long hold-off, sampled at the falling edge
	always begin
		@(posedge clk);
		if (hold_request > 0) begin
			sink_hold_left = hold_request;
			hold_request = 0;
		end
		if (sink_hold_left > 0) begin
			result_stall <= 1'b1;
			sink_hold_left--;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
		@(negedge clk);
		if (arst_n && result_valid && !result_stall)
			check_token(result);
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ---------------------------------------------------------------- stimulus

	// one input beat; entered and left at a rising edge
	task automatic send_beat(input item_t it);
		int unsigned gap;
		bit          stalled;
		result_t     res;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		stalled = 1'b1;
		while (stalled) begin
			@(negedge clk);
			stalled = item_stall;
			@(posedge clk);
		end
		items_sent++;
		if (predict_token(it, res))
			expected_tokens.insert(expected_tokens.size(), res);
	endtask

	task automatic send_byte(input logic [7:0] b);
		item_t it;
		it.func = FUNC_BYTE;
		it.byte_in = b;
		send_beat(it);
	endtask

	task automatic send_eof();
		item_t it;
		it.func = FUNC_EOF;
		it.byte_in = 8'($urandom);
		send_beat(it);
	endtask

	// pause the sender until every expected token is out
	task automatic wait_for_tokens();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_tokens.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_blank();
		if ($urandom_range(0, 5) == 0)
			return CH_SPACE;
		return CH_TAB + 8'($urandom_range(0, 4));
	endfunction

	function automatic logic [7:0] pick_other(logic [7:0] a, logic [7:0] b);
		logic [7:0] r;
		r = 8'($urandom);
		while (r == a || r == b)
			r = 8'($urandom);
		return r;
	endfunction

	// a byte that is misplaced between tokens where 'wanted' is awaited
	function automatic logic [7:0] pick_stray(logic [7:0] wanted);
		logic [7:0] r;
		r = 8'($urandom);
		while (is_blank(r) || r == CH_SLASH || r == wanted)
			r = 8'($urandom);
		return r;
	endfunction

	task automatic send_string_body(int unsigned n);
		repeat (n) begin
			if ($urandom_range(0, 6) == 0) begin
				send_byte(CH_BSLASH);
				send_byte(8'($urandom));
			end else begin
				send_byte(pick_other(CH_QUOTE, CH_BSLASH));
			end
		end
	endtask

	task automatic send_string(int unsigned max_len);
		send_byte(CH_QUOTE);
		send_string_body($urandom_range(0, max_len));
		send_byte(CH_QUOTE);
	endtask

	task automatic send_line_comment();
		send_byte(CH_SLASH);
		send_byte(CH_SLASH);
		repeat ($urandom_range(0, 6))
			send_byte(pick_other(CH_LF, CH_LF));
		send_byte(CH_LF);
	endtask

	// block comment with star runs inside and one or more stars before the close
	task automatic send_block_comment();
		logic [7:0] b;
		send_byte(CH_SLASH);
		send_byte(CH_STAR);
		repeat ($urandom_range(0, 6)) begin
			b = ($urandom_range(0, 4) == 0) ? CH_STAR : 8'($urandom);
			if (b == CH_STAR) begin
				repeat ($urandom_range(1, 3))
					send_byte(CH_STAR);
				send_byte(pick_other(CH_STAR, CH_SLASH));
			end else begin
				send_byte(b);
			end
		end
		repeat ($urandom_range(1, 3))
			send_byte(CH_STAR);
		send_byte(CH_SLASH);
	endtask

	task automatic send_filler(int unsigned max_parts);
		repeat ($urandom_range(0, max_parts)) begin
			case ($urandom_range(0, 5))
				0: send_line_comment();
				1: send_block_comment();
				default: send_byte(pick_blank());
			endcase
		end
	endtask

	task automatic send_pair(int unsigned key_max, int unsigned val_max);
		send_filler(3);
		send_string(key_max);
		send_filler(2);
		send_byte(CH_EQUALS);
		send_filler(2);
		send_string(val_max);
	endtask

	// ---------------------------------------------------------------- tests

	// header with extreme and escaped bytes, stacked comments, empty pair
	task automatic test_directed();
		send_byte(CH_SLASH);
		send_byte(CH_STAR);
		send_byte(CH_STAR);
		send_byte(CH_SLASH);
		send_byte(CH_SLASH);
		send_byte(CH_STAR);
		send_byte(CH_STAR);
		send_byte(CH_STAR);
		send_byte(CH_SLASH);
		send_byte(CH_SLASH);
		send_byte(CH_SLASH);
		send_byte(CH_LF);
		send_byte(CH_VT);
		send_byte(CH_QUOTE);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CH_BSLASH);
		send_byte(CH_QUOTE);
		send_byte(CH_BSLASH);
		send_byte(CH_BSLASH);
		send_byte(CH_BSLASH);
		send_byte(CH_LF);
		send_byte(CH_LF);
		send_byte(CH_QUOTE);
		send_byte(CH_FF);
		send_byte(CH_QUOTE);
		send_byte(CH_QUOTE);
		send_byte(CH_EQUALS);
		send_byte(CH_QUOTE);
		send_byte(CH_QUOTE);
	endtask

	// well-formed pairs with random content; malformed input would halt the
	// block for the rest of the run, so it is kept for the file ending
	task automatic test_random_pairs(int unsigned n);
		int unsigned start;
		start = items_sent;
		while (items_sent - start < n)
			send_pair(6, 10);
	endtask

	// receiver holds off while long values keep coming, so the core fills up
	task automatic test_backpressure();
		int saved_idle;
		saved_idle = send_idle_pct;
		send_idle_pct = 0;
		hold_request = HOLD_CYCLES;
		repeat (3)
			send_pair(4, 40);
		send_idle_pct = saved_idle;
		wait_for_tokens();
	endtask

	// newlines between tokens, then plain and escaped newlines inside a key
	task automatic test_line_count();
		repeat ($urandom_range(1, 8))
			send_byte(CH_LF);
		send_filler(2);
		send_byte(CH_QUOTE);
		send_byte(CH_LF);
		send_byte(CH_BSLASH);
		send_byte(CH_LF);
		send_byte(CH_QUOTE);
		send_byte(CH_EQUALS);
		send_string(6);
	endtask

	task automatic test_file_ending(file_ending_t e);
		case (e)
			END_EMPTY_FILE: begin
				send_filler(2);
				send_eof();
			end
			END_STRAY_BEFORE_HDR: send_byte(pick_stray(CH_QUOTE));
			END_EOF_IN_HDR: begin
				send_byte(CH_QUOTE);
				send_string_body($urandom_range(0, 4));
				send_eof();
			end
			END_CLEAN: begin
				send_filler(3);
				send_eof();
			end
			END_EOF_LINE_CMT: begin
				send_byte(CH_SLASH);
				send_byte(CH_SLASH);
				repeat ($urandom_range(0, 4))
					send_byte(pick_other(CH_LF, CH_LF));
				send_eof();
			end
			END_EOF_BLOCK_CMT: begin
				send_byte(CH_SLASH);
				send_byte(CH_STAR);
				repeat ($urandom_range(0, 3))
					send_byte(CH_STAR);
				send_eof();
			end
			END_EOF_AFTER_SLASH: begin
				send_byte(CH_SLASH);
				send_eof();
			end
			END_BAD_COMMENT_START: begin
				send_byte(CH_SLASH);
				send_byte(pick_other(CH_SLASH, CH_STAR));
			end
			END_STRAY_AT_KEY: begin
				send_filler(2);
				send_byte(pick_stray(CH_QUOTE));
			end
			END_EOF_IN_KEY: begin
				send_byte(CH_QUOTE);
				send_string_body($urandom_range(0, 4));
				send_eof();
			end
			END_EOF_ESC_VALUE: begin
				send_string(4);
				send_byte(CH_EQUALS);
				send_byte(CH_QUOTE);
				send_string_body($urandom_range(0, 4));
				send_byte(CH_BSLASH);
				send_eof();
			end
			END_STRAY_AT_EQUALS: begin
				send_string(4);
				send_filler(2);
				send_byte(pick_stray(CH_EQUALS));
			end
			END_EOF_AT_EQUALS: begin
				send_string(4);
				send_filler(2);
				send_eof();
			end
			END_EOF_AT_VALUE: begin
				send_string(4);
				send_byte(CH_EQUALS);
				send_filler(2);
				send_eof();
			end
			default: begin
				send_string(4);
				send_byte(CH_EQUALS);
				send_byte(pick_stray(CH_QUOTE));
			end
		endcase
	endtask

	// once halted, every beat repeats the halting token
	task automatic test_after_halt();
		repeat (20) begin
			if ($urandom_range(0, 2) == 0)
				send_eof();
			else
				send_byte(8'($urandom));
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin : main_seq
		file_ending_t ending;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// endings before the header leave the whole run halted, so keep them rare
		ending = file_ending_t'($urandom_range(END_EMPTY_FILE, END_STRAY_AT_VALUE));
		if (ending <= END_EOF_IN_HDR && $urandom_range(0, 1) == 0)
			ending = END_CLEAN;
		if (ending <= END_EOF_IN_HDR)
			test_file_ending(ending);

		// light sender gaps, heavy output stall
		send_idle_pct = 23;
		recv_stall_pct = 87;
		test_directed();
		test_random_pairs(470);
		wait_for_tokens();

		// heavy sender gaps, light output stall
		send_idle_pct = 87;
		recv_stall_pct = 23;
		test_random_pairs(470);
		test_backpressure();

		// full rate
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_pairs(470);
		if (!tok_halted) begin
			test_line_count();
			test_file_ending(ending);
		end
		test_after_halt();

		wait_for_tokens();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### sim.f
hw/rtl/qpft_pkg.sv
hw/rtl/qpft_step.sv
hw/rtl/quoted_pair_file_tokenizer_core.sv
bench/tb_top.sv
